>>> rtl/tcc_pkg.sv
// Shared types, codes and helpers for the telephone call control block.
`timescale 1ns / 1ps

package tcc_pkg;

  localparam int MAX_UNITS = 16;
  localparam int IDX_W     = $clog2(MAX_UNITS);
  localparam int EXT_W     = 10;

  // operation codes
  localparam logic [2:0] OP_REGISTER   = 3'd0;
  localparam logic [2:0] OP_UNREGISTER = 3'd1;
  localparam logic [2:0] OP_PICKUP     = 3'd2;
  localparam logic [2:0] OP_HANGUP     = 3'd3;
  localparam logic [2:0] OP_DIAL       = 3'd4;
  localparam logic [2:0] OP_CHAT       = 3'd5;

  // call states
  localparam logic [2:0] ST_ON_HOOK   = 3'd0;
  localparam logic [2:0] ST_RINGING   = 3'd1;
  localparam logic [2:0] ST_DIAL_TONE = 3'd2;
  localparam logic [2:0] ST_RING_BACK = 3'd3;
  localparam logic [2:0] ST_BUSY      = 3'd4;
  localparam logic [2:0] ST_CONNECTED = 3'd5;
  localparam logic [2:0] ST_ERROR     = 3'd6;

  // notice codes (a call state uses the same code as its notice)
  localparam logic [3:0] NT_ON_HOOK   = 4'd0;
  localparam logic [3:0] NT_RINGING   = 4'd1;
  localparam logic [3:0] NT_DIAL_TONE = 4'd2;
  localparam logic [3:0] NT_RING_BACK = 4'd3;
  localparam logic [3:0] NT_BUSY      = 4'd4;
  localparam logic [3:0] NT_CONNECTED = 4'd5;
  localparam logic [3:0] NT_ERROR     = 4'd6;
  localparam logic [3:0] NT_CHAT      = 4'd7;
  localparam logic [3:0] NT_NONE      = 4'd8;

  typedef struct packed {
    logic [EXT_W-1:0] ext;
    logic [2:0]       call_st;
    logic [EXT_W-1:0] peer;
    logic             has_peer;
  } entry_t;

  typedef struct packed {
    logic [EXT_W-1:0] dest;
    logic [3:0]       notice;
    logic [EXT_W-1:0] peer;
    logic             failed;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic look;
    logic peer;
    logic exec;
    logic wr_s;
    logic out_sel;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic two;
  } ctl_status_t;

  function automatic result_t mk_res(logic [EXT_W-1:0] dest, logic [3:0] notice,
                                     logic [EXT_W-1:0] peer, logic failed);
    result_t r;
    r.dest   = dest;
    r.notice = notice;
    r.peer   = peer;
    r.failed = failed;
    return r;
  endfunction

endpackage

>>> rtl/tcc_ctrl.sv
// Sequencer for the call switch: lookup, peer lookup, updates, notices.
`timescale 1ns / 1ps

module tcc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  tcc_pkg::ctl_status_t status,
  output tcc_pkg::ctl_cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LOOK = 7'b0000010,
    S_PEER = 7'b0000100,
    S_EXEC = 7'b0001000,
    S_WR_S = 7'b0010000,
    S_OUT0 = 7'b0100000,
    S_OUT1 = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look   = 1'b1;
        state_next = S_PEER;
      end
      S_PEER: begin
        cmd.peer   = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_WR_S;
      end
      S_WR_S: begin
        cmd.wr_s   = 1'b1;
        state_next = S_OUT0;
      end
      S_OUT0: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = status.two ? S_OUT1 : S_IDLE;
        end
      end
      S_OUT1: begin
        out_valid   = 1'b1;
        cmd.out_sel = 1'b1;
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/tcc_datapath.sv
// Unit table, extension search, call decision and notice registers.
`timescale 1ns / 1ps

module tcc_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  tcc_pkg::ctl_cmd_t                    cmd,
  output tcc_pkg::ctl_status_t                 status,
  input  logic [2:0]                           operation,
  input  logic [tcc_pkg::EXT_W-1:0]            unit_ext,
  input  logic signed [tcc_pkg::EXT_W:0]       dial_ext,
  output logic [tcc_pkg::EXT_W-1:0]            dest_ext,
  output logic [3:0]                           notice,
  output logic [tcc_pkg::EXT_W-1:0]            peer_ext,
  output logic                                 failed,
  output logic                                 last
);

  // table
  logic [tcc_pkg::MAX_UNITS-1:0] slot_used;
  tcc_pkg::entry_t               slot_ent [tcc_pkg::MAX_UNITS];

  // captured item
  logic [2:0]                op;
  logic [tcc_pkg::EXT_W-1:0] u;
  logic [tcc_pkg::EXT_W:0]   d;

  // lookup results
  logic                      s_found;
  logic [tcc_pkg::IDX_W-1:0] s_idx;
  tcc_pkg::entry_t           s_ent;
  logic                      free_found;
  logic [tcc_pkg::IDX_W-1:0] free_idx;
  logic                      p_found;
  logic [tcc_pkg::IDX_W-1:0] p_idx;
  tcc_pkg::entry_t           p_ent;

  // planned requester write and notices
  logic                      s_we;
  logic [tcc_pkg::IDX_W-1:0] s_wr_idx;
  logic                      s_wr_used;
  tcc_pkg::entry_t           s_wr_ent;
  tcc_pkg::result_t          res0;
  tcc_pkg::result_t          res1;
  logic                      two;

  // shared search
  logic [tcc_pkg::EXT_W-1:0] key;
  logic                      hit;
  logic [tcc_pkg::IDX_W-1:0] hit_idx;
  logic                      free_hit;
  logic [tcc_pkg::IDX_W-1:0] free_hit_idx;
  tcc_pkg::entry_t           hit_ent;

  // decision
  logic                      p_we_c;
  tcc_pkg::entry_t           p_new_c;
  logic                      s_we_c;
  logic                      s_used_c;
  tcc_pkg::entry_t           s_new_c;
  tcc_pkg::result_t          r0_c;
  tcc_pkg::result_t          r1_c;
  logic                      two_c;
  logic                      in_call;
  logic [2:0]                hang_st;

  always_comb begin
    if (cmd.look) begin
      key = u;
    end else if (op == tcc_pkg::OP_DIAL) begin
      key = d[tcc_pkg::EXT_W-1:0];
    end else begin
      key = s_ent.peer;
    end
  end

  // lowest matching slot wins
  always_comb begin
    hit          = 1'b0;
    hit_idx      = '0;
    free_hit     = 1'b0;
    free_hit_idx = '0;
    for (int i = tcc_pkg::MAX_UNITS - 1; i >= 0; i--) begin
      if (slot_used[i] && slot_ent[i].ext == key) begin
        hit     = 1'b1;
        hit_idx = tcc_pkg::IDX_W'(i);
      end
      if (!slot_used[i]) begin
        free_hit     = 1'b1;
        free_hit_idx = tcc_pkg::IDX_W'(i);
      end
    end
    hit_ent = slot_ent[hit_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op <= operation;
      u  <= unit_ext;
      d  <= dial_ext;
    end
    if (cmd.look) begin
      s_found    <= hit;
      s_idx      <= hit_idx;
      s_ent      <= hit_ent;
      free_found <= free_hit;
      free_idx   <= free_hit_idx;
    end
    if (cmd.peer) begin
      p_found <= hit && (op == tcc_pkg::OP_DIAL || s_ent.has_peer);
      p_idx   <= hit_idx;
      p_ent   <= hit_ent;
    end
    if (cmd.exec) begin
      s_we      <= s_we_c;
      s_wr_idx  <= (op == tcc_pkg::OP_REGISTER) ? free_idx : s_idx;
      s_wr_used <= s_used_c;
      s_wr_ent  <= s_new_c;
      res0      <= r0_c;
      res1      <= r1_c;
      two       <= two_c;
    end
  end

  always_comb begin
    p_we_c   = 1'b0;
    p_new_c  = p_ent;
    s_we_c   = 1'b0;
    s_used_c = 1'b1;
    s_new_c  = s_ent;
    r0_c     = tcc_pkg::mk_res(u, tcc_pkg::NT_NONE, '0, 1'b1);
    r1_c     = r0_c;
    two_c    = 1'b0;
    in_call  = s_ent.call_st == tcc_pkg::ST_CONNECTED ||
               s_ent.call_st == tcc_pkg::ST_RINGING ||
               s_ent.call_st == tcc_pkg::ST_RING_BACK;
    hang_st  = (s_ent.call_st == tcc_pkg::ST_RING_BACK) ? tcc_pkg::ST_ON_HOOK
                                                        : tcc_pkg::ST_DIAL_TONE;
    if (op == tcc_pkg::OP_REGISTER) begin
      if (!s_found && free_found) begin
        s_we_c           = 1'b1;
        s_new_c.ext      = u;
        s_new_c.call_st  = tcc_pkg::ST_ON_HOOK;
        s_new_c.peer     = '0;
        s_new_c.has_peer = 1'b0;
        r0_c = tcc_pkg::mk_res(u, tcc_pkg::NT_ON_HOOK, u, 1'b0);
      end
    end else if (s_found) begin
      case (op)
        tcc_pkg::OP_UNREGISTER: begin
          s_we_c           = 1'b1;
          s_used_c         = 1'b0;
          s_new_c.has_peer = 1'b0;
          r0_c = tcc_pkg::mk_res(u, tcc_pkg::NT_NONE, '0, 1'b0);
        end
        tcc_pkg::OP_PICKUP: begin
          r0_c = tcc_pkg::mk_res(u, tcc_pkg::NT_NONE, '0, 1'b0);
          if (s_ent.call_st == tcc_pkg::ST_ON_HOOK) begin
            s_we_c          = 1'b1;
            s_new_c.call_st = tcc_pkg::ST_DIAL_TONE;
            r0_c = tcc_pkg::mk_res(u, tcc_pkg::NT_DIAL_TONE, '0, 1'b0);
          end else if (s_ent.call_st == tcc_pkg::ST_RINGING && p_found) begin
            p_we_c          = 1'b1;
            p_new_c.call_st = tcc_pkg::ST_CONNECTED;
            s_we_c          = 1'b1;
            s_new_c.call_st = tcc_pkg::ST_CONNECTED;
            two_c = 1'b1;
            r0_c  = tcc_pkg::mk_res(p_ent.ext, tcc_pkg::NT_CONNECTED, u, 1'b0);
            r1_c  = tcc_pkg::mk_res(u, tcc_pkg::NT_CONNECTED, p_ent.ext, 1'b0);
          end
        end
        tcc_pkg::OP_HANGUP: begin
          s_we_c          = 1'b1;
          s_new_c.call_st = tcc_pkg::ST_ON_HOOK;
          if (in_call) begin
            s_new_c.has_peer = 1'b0;
          end
          r0_c = tcc_pkg::mk_res(u, tcc_pkg::NT_ON_HOOK, u, 1'b0);
          if (in_call && p_found) begin
            p_we_c           = 1'b1;
            p_new_c.has_peer = 1'b0;
            p_new_c.call_st  = hang_st;
            two_c = 1'b1;
            r0_c  = tcc_pkg::mk_res(p_ent.ext, {1'b0, hang_st},
                      (hang_st == tcc_pkg::ST_ON_HOOK) ? p_ent.ext : '0, 1'b0);
            r1_c  = tcc_pkg::mk_res(u, tcc_pkg::NT_ON_HOOK, u, 1'b0);
          end
        end
        tcc_pkg::OP_DIAL: begin
          if (d[tcc_pkg::EXT_W]) begin
            r0_c = tcc_pkg::mk_res(u, tcc_pkg::NT_NONE, '0, 1'b1);
          end else if (!p_found) begin
            s_we_c          = 1'b1;
            s_new_c.call_st = tcc_pkg::ST_ERROR;
            r0_c = tcc_pkg::mk_res(u, tcc_pkg::NT_ERROR, '0, 1'b1);
          end else if (s_ent.call_st != tcc_pkg::ST_DIAL_TONE) begin
            r0_c = tcc_pkg::mk_res(u, tcc_pkg::NT_NONE, '0, 1'b0);
          end else if (p_idx != s_idx && p_ent.call_st == tcc_pkg::ST_ON_HOOK) begin
            p_we_c           = 1'b1;
            p_new_c.peer     = u;
            p_new_c.has_peer = 1'b1;
            p_new_c.call_st  = tcc_pkg::ST_RINGING;
            s_we_c           = 1'b1;
            s_new_c.peer     = p_ent.ext;
            s_new_c.has_peer = 1'b1;
            s_new_c.call_st  = tcc_pkg::ST_RING_BACK;
            two_c = 1'b1;
            r0_c  = tcc_pkg::mk_res(u, tcc_pkg::NT_RING_BACK, '0, 1'b0);
            r1_c  = tcc_pkg::mk_res(p_ent.ext, tcc_pkg::NT_RINGING, '0, 1'b0);
          end else begin
            s_we_c          = 1'b1;
            s_new_c.call_st = tcc_pkg::ST_BUSY;
            r0_c = tcc_pkg::mk_res(u, tcc_pkg::NT_BUSY, '0, 1'b0);
          end
        end
        tcc_pkg::OP_CHAT: begin
          if (s_ent.call_st == tcc_pkg::ST_CONNECTED) begin
            two_c = 1'b1;
            r0_c  = tcc_pkg::mk_res(s_ent.peer, tcc_pkg::NT_CHAT, u, 1'b0);
            r1_c  = tcc_pkg::mk_res(u, tcc_pkg::NT_CONNECTED, s_ent.peer, 1'b0);
          end
        end
        default: begin
          r0_c = tcc_pkg::mk_res(u, tcc_pkg::NT_NONE, '0, 1'b1);
        end
      endcase
    end
  end

  // peer entry first, requester entry in the cycle after
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used <= '0;
    end else if (cmd.wr_s && s_we) begin
      slot_used[s_wr_idx] <= s_wr_used;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && p_we_c) begin
      slot_ent[p_idx] <= p_new_c;
    end else if (cmd.wr_s && s_we) begin
      slot_ent[s_wr_idx] <= s_wr_ent;
    end
  end

  assign status.two = two;

  always_comb begin
    if (cmd.out_sel) begin
      dest_ext = res1.dest;
      notice   = res1.notice;
      peer_ext = res1.peer;
      failed   = res1.failed;
    end else begin
      dest_ext = res0.dest;
      notice   = res0.notice;
      peer_ext = res0.peer;
      failed   = res0.failed;
    end
    last = cmd.out_sel || !two;
  end

endmodule

>>> rtl/telephone_call_control.sv
// Top level of the telephone call switch: sequencer plus unit table datapath.
`timescale 1ns / 1ps

//  channel   handshake              payload
//  input     in_valid / in_ready    operation, unit_ext, dial_ext
//  output    out_valid / out_ready  dest_ext, notice, peer_ext, failed, last
//
//  The sequencer walks each accepted operation through requester search, peer
//  search, peer update and requester update, then gives one notice word or two,
//  each held until out_ready is high; the next operation is accepted after that.
//  Reset (rst, synchronous) marks every table slot free and idles the sequencer.
//  A stalled notice word holds on the output ports; input is refused meanwhile.

module telephone_call_control (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [2:0]                      operation,
  input  logic [tcc_pkg::EXT_W-1:0]       unit_ext,
  input  logic signed [tcc_pkg::EXT_W:0]  dial_ext,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tcc_pkg::EXT_W-1:0]       dest_ext,
  output logic [3:0]                      notice,
  output logic [tcc_pkg::EXT_W-1:0]       peer_ext,
  output logic                            failed,
  output logic                            last
);

  // command and status between sequencer and datapath
  tcc_pkg::ctl_cmd_t    cmd;
  tcc_pkg::ctl_status_t status;

  // sequencer: walks each operation through search, update and notice steps
  tcc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: unit table, shared extension search, call decision, notices
  tcc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .operation (operation),
    .unit_ext  (unit_ext),
    .dial_ext  (dial_ext),
    .dest_ext  (dest_ext),
    .notice    (notice),
    .peer_ext  (peer_ext),
    .failed    (failed),
    .last      (last)
  );

endmodule
